/* design/ptb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Prime table package
// Shared types and constants for the prime table builder and query unit.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int unsigned PRIME_LIMIT_W = 12;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned COUNT_OUT_W   = 11;

  localparam logic [PRIME_LIMIT_W-1:0] PRIME_LIMIT_RESET = 12'd100;
  localparam logic [VALUE_W-1:0]       FIRST_PRIME       = 32'd2;

  typedef enum logic [0:0] {
    CMD_BUILD = 1'b0,
    CMD_QUERY = 1'b1
  } ptb_cmd_e;

  typedef logic [PRIME_LIMIT_W-1:0] prime_limit_t;

  typedef struct packed {
    ptb_cmd_e                   command;
    logic signed [VALUE_W-1:0]  query_value;
  } ptb_in_t;

  typedef struct packed {
    logic                   prime_flag;
    logic [COUNT_OUT_W-1:0] prime_count;
  } ptb_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B_NEXT,
    ST_B_TEST,
    ST_B_DIV,
    ST_Q_CHECK,
    ST_Q_CMP,
    ST_Q_DIV,
    ST_FINISH
  } ptb_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic build_init;
    logic q_init;
    logic n_next;
    logic d_init;
    logic d_next;
    logic store_prime;
    logic div_start_n;
    logic div_start_q;
    logic rd_issue;
    logic k_next;
    logic mark_prime;
    logic out_load;
  } ptb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_over;
    logic full;
    logic sq_gt_n;
    logic div_done;
    logic rem_zero;
    logic q_trivial;
    logic k_end;
    logic p_eq;
    logic p_gt;
  } ptb_status_t;

endpackage
`default_nettype wire

/* design/ptb_chan_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Valid/ready channel
// One valid/ready channel with a payload of a configurable type.
// ----------------------------------------------------------------------------
interface ptb_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/ptb_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring remainder of a 32-bit dividend by a narrow divisor, one bit per
// cycle.
// ----------------------------------------------------------------------------
module ptb_div #(
  parameter int unsigned DIVISOR_W = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ptb_pkg::VALUE_W-1:0]   dividend_i,
  input  wire logic [DIVISOR_W-1:0]          divisor_i,
  output logic                               done_o,
  output logic                               rem_zero_o
);
  import ptb_pkg::*;

  localparam int unsigned StepW = $clog2(VALUE_W + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [StepW-1:0]     step_q;
  logic [VALUE_W-1:0]   dvd_q;
  logic [DIVISOR_W-1:0] dsr_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic [DIVISOR_W-1:0] rem_d;

  always_comb begin
    shifted = {rem_q, dvd_q[VALUE_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    if (shifted >= {1'b0, dsr_q}) begin
      rem_d = diff[DIVISOR_W-1:0];
    end else begin
      rem_d = shifted[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(VALUE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[VALUE_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign rem_zero_o = (rem_q == '0);

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("remainder unit started while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("remainder unit did not go busy after start");
`endif

endmodule
`default_nettype wire

/* design/ptb_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Prime table datapath
// Limit register, prime table memory, build and query counters, shared
// remainder unit and result register.
// ----------------------------------------------------------------------------
module ptb_dp #(
  parameter int unsigned LIMIT_MAX   = 4096,
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ptb_pkg::ptb_cmd_t            cmd_i,
  output ptb_pkg::ptb_status_t              status_o,
  input  wire ptb_pkg::ptb_in_t             in_data_i,
  input  wire logic                         cfg_we_i,
  input  wire ptb_pkg::prime_limit_t        cfg_data_i,
  output ptb_pkg::ptb_out_t                 out_data_o
);
  import ptb_pkg::*;

  localparam int unsigned CandW = $clog2(LIMIT_MAX);
  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LimTop = LIMIT_MAX - 1;

  prime_limit_t        prime_limit_q;
  logic [CntW-1:0]     count_q;
  logic [CntW-1:0]     k_q;
  logic [CandW:0]      n_q;
  logic [CandW-1:0]    d_q;
  logic [CandW+1:0]    sq_q;
  logic [VALUE_W-1:0]  mag_q;
  logic                verdict_q;
  logic [CandW-1:0]    rd_data_q;
  logic [CandW-1:0]    table_q [TABLE_DEPTH];
  ptb_out_t            out_q;

  logic [31:0]         lim_full;
  logic [CandW-1:0]    lim;
  logic                div_start;
  logic [VALUE_W-1:0]  div_dividend;
  logic [CandW-1:0]    div_divisor;
  logic                div_done;
  logic                div_rem_zero;

  // A limit beyond the table's candidate range saturates to the top value.
  always_comb begin
    if (32'(prime_limit_q) >= LIMIT_MAX) begin
      lim_full = LimTop;
    end else begin
      lim_full = 32'(prime_limit_q);
    end
    lim = lim_full[CandW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_limit_q <= PRIME_LIMIT_RESET;
    end else if (cfg_we_i) begin
      prime_limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      verdict_q <= 1'b0;
    end else begin
      if (cmd_i.build_init) begin
        count_q <= '0;
      end else if (cmd_i.store_prime) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.build_init || cmd_i.q_init) begin
        verdict_q <= 1'b0;
      end else if (cmd_i.mark_prime) begin
        verdict_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_init) begin
      n_q <= (CandW + 1)'(FIRST_PRIME);
    end else if (cmd_i.n_next) begin
      n_q <= n_q + (CandW + 1)'(1);
    end
    if (cmd_i.d_init) begin
      d_q  <= CandW'(FIRST_PRIME);
      sq_q <= (CandW + 2)'(FIRST_PRIME * FIRST_PRIME);
    end else if (cmd_i.d_next) begin
      // (d + 1)^2 = d^2 + 2d + 1
      d_q  <= d_q + CandW'(1);
      sq_q <= sq_q + (CandW + 2)'({d_q, 1'b1});
    end
    if (cmd_i.q_init) begin
      mag_q <= unsigned'(in_data_i.query_value);
      k_q   <= '0;
    end else if (cmd_i.k_next) begin
      k_q <= k_q + CntW'(1);
    end
    if (cmd_i.out_load) begin
      out_q.prime_flag  <= verdict_q;
      out_q.prime_count <= COUNT_OUT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_prime) begin
      table_q[count_q[AddrW-1:0]] <= n_q[CandW-1:0];
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= table_q[k_q[AddrW-1:0]];
    end
  end

  assign div_start    = cmd_i.div_start_n || cmd_i.div_start_q;
  assign div_dividend = cmd_i.div_start_n ? VALUE_W'(n_q) : mag_q;
  assign div_divisor  = cmd_i.div_start_n ? d_q : rd_data_q;

  ptb_div #(
    .DIVISOR_W (CandW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .rem_zero_o (div_rem_zero)
  );

  always_comb begin
    status_o.n_over    = n_q > {1'b0, lim};
    status_o.full      = count_q == CntW'(TABLE_DEPTH);
    status_o.sq_gt_n   = sq_q > (CandW + 2)'(n_q);
    status_o.div_done  = div_done;
    status_o.rem_zero  = div_rem_zero;
    // Negative numbers, zero and one are never prime.
    status_o.q_trivial = mag_q[VALUE_W-1] || (mag_q < FIRST_PRIME);
    status_o.k_end     = k_q >= count_q;
    status_o.p_eq      = mag_q == VALUE_W'(rd_data_q);
    status_o.p_gt      = VALUE_W'(rd_data_q) > mag_q;
  end

  assign out_data_o = out_q;

`ifndef ASSERT_OFF
  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_prime |-> (count_q < CntW'(TABLE_DEPTH)))
    else $error("prime stored into a full table");

  a_read_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_issue |-> (k_q < count_q))
    else $error("table read beyond the filled entries");

  a_mark_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark_prime |-> (mag_q == VALUE_W'(rd_data_q)) && !mag_q[VALUE_W-1])
    else $error("prime verdict without a matching table entry");
`endif

endmodule
`default_nettype wire

/* design/ptb_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Prime table controller
// Sequences table builds, queries and the result handshake.
// ----------------------------------------------------------------------------
module ptb_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire ptb_pkg::ptb_cmd_e     in_command_i,
  output logic                       in_ready_o,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  input  wire ptb_pkg::ptb_status_t  status_i,
  output ptb_pkg::ptb_cmd_t          cmd_o
);
  import ptb_pkg::*;

  ptb_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_command_i == CMD_BUILD) begin
            cmd_o.build_init = 1'b1;
            state_d          = ST_B_NEXT;
          end else begin
            cmd_o.q_init = 1'b1;
            state_d      = ST_Q_CHECK;
          end
        end
      end
      ST_B_NEXT: begin
        if (status_i.n_over || status_i.full) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.d_init = 1'b1;
          state_d      = ST_B_TEST;
        end
      end
      ST_B_TEST: begin
        if (status_i.sq_gt_n) begin
          cmd_o.store_prime = 1'b1;
          cmd_o.n_next      = 1'b1;
          state_d           = ST_B_NEXT;
        end else begin
          cmd_o.div_start_n = 1'b1;
          state_d           = ST_B_DIV;
        end
      end
      ST_B_DIV: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            cmd_o.n_next = 1'b1;
            state_d      = ST_B_NEXT;
          end else begin
            cmd_o.d_next = 1'b1;
            state_d      = ST_B_TEST;
          end
        end
      end
      ST_Q_CHECK: begin
        if (status_i.q_trivial || status_i.k_end) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_Q_CMP;
        end
      end
      ST_Q_CMP: begin
        // The table is ascending, so an entry above the number ends the walk.
        priority if (status_i.p_eq) begin
          cmd_o.mark_prime = 1'b1;
          state_d          = ST_FINISH;
        end else if (status_i.p_gt) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.div_start_q = 1'b1;
          state_d           = ST_Q_DIV;
        end
      end
      ST_Q_DIV: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            state_d = ST_FINISH;
          end else begin
            cmd_o.k_next = 1'b1;
            state_d      = ST_Q_CHECK;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_start_n || cmd_o.div_start_q) |=> !status_i.div_done)
    else $error("remainder done too early after start");

  a_single_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.build_init && cmd_o.q_init))
    else $error("build and query started together");
`endif

endmodule
`default_nettype wire

/* design/prime_table_builder_and_query_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Prime table builder and query unit
// Builds a table of primes by trial division and answers primality queries
// by walking that table.
// ----------------------------------------------------------------------------
// One request is handled at a time; the result waits in an output register,
// so a new request is taken as soon as the result is loaded, which waits
// only while an earlier result is still untaken. Every remainder is
// computed by one shared restoring unit at one bit per cycle. A query
// divides by the table entries in ascending order until one divides the
// number, equals it or exceeds it, or the filled entries run out; negative
// numbers, 0 and 1 answer without any division. A build tries each trial
// divisor of each candidate from 2 to the limit until its square exceeds
// the candidate, and stops early once the table is full. The prime count
// in the result is the table fill after the request. The table memory needs
// no clearing pass.
module prime_table_builder_and_query_unit #(
  parameter int unsigned LIMIT_MAX   = 4096,
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ptb_chan_if.sink   in_req,
  ptb_chan_if.source out_rsp,
  ptb_chan_if.sink   cfg_req
);
  import ptb_pkg::*;

  ptb_cmd_t    cmd;
  ptb_status_t status;
  ptb_in_t     in_data;
  ptb_out_t    out_data;

  assign in_data       = in_req.data;
  assign cfg_req.ready = 1'b1;
  assign out_rsp.data  = out_data;

  ptb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_req.valid),
    .in_command_i (in_data.command),
    .in_ready_o   (in_req.ready),
    .out_ready_i  (out_rsp.ready),
    .out_valid_o  (out_rsp.valid),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  ptb_dp #(
    .LIMIT_MAX   (LIMIT_MAX),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data),
    .cfg_we_i   (cfg_req.valid),
    .cfg_data_i (cfg_req.data),
    .out_data_o (out_data)
  );

endmodule
`default_nettype wire

/* sim/prime_table_builder_and_query_unit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime table checker
// Watches the request, result and limit channels of the prime table unit,
// keeps its own prime table and limit, predicts the answer to every accepted
// request and compares it field by field with the results in order.
// ----------------------------------------------------------------------------
module prime_table_builder_and_query_unit_checker #(
  parameter int unsigned LIMIT_MAX   = 4096,
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire ptb_pkg::ptb_in_t      in_data_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire ptb_pkg::ptb_out_t     out_data_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire ptb_pkg::prime_limit_t cfg_data_i,
  output int unsigned                fail_count_o,
  output int unsigned                outstanding_o
);
  import ptb_pkg::*;

  prime_limit_t             limit_q;
  logic [PRIME_LIMIT_W-1:0] prime_store [TABLE_DEPTH];
  int unsigned              prime_total;
  int unsigned              mismatch_total;
  ptb_out_t                 answer_q [$];

  function automatic bit is_trial_prime(int unsigned n);
    int unsigned d;
    if (n < FIRST_PRIME) return 1'b0;
    for (d = FIRST_PRIME; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void rebuild_table();
    int unsigned top_n;
    int unsigned n;
    top_n = 32'(limit_q);
    if (top_n >= LIMIT_MAX) top_n = LIMIT_MAX - 1;
    prime_total = 0;
    for (n = FIRST_PRIME; n <= top_n; n++) begin
      if (prime_total >= TABLE_DEPTH) break;
      if (is_trial_prime(n)) begin
        prime_store[prime_total] = n[PRIME_LIMIT_W-1:0];
        prime_total++;
      end
    end
  endfunction

  function automatic logic answer_query(logic [VALUE_W-1:0] raw);
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] p;
    int unsigned        k;
    neg = raw[VALUE_W-1];
    // The most negative number wraps to its own bit pattern, 2^31 unsigned.
    mag = neg ? ({VALUE_W{1'b0}} - raw) : raw;
    for (k = 0; k < prime_total && k < TABLE_DEPTH; k++) begin
      p = VALUE_W'(prime_store[k]);
      if (p == 0) return 1'b0;
      if (!neg && mag == p) return 1'b1;
      if (mag % p == 0) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic void flag_mismatch(string field, int unsigned want_v,
                                        int unsigned got_v);
    mismatch_total++;
    $display("%0t: %s mismatch, expected %0d, actual %0d",
             $time, field, want_v, got_v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ptb_out_t want;
    if (!rst_ni) begin
      limit_q        = PRIME_LIMIT_RESET;
      prime_total    = 0;
      mismatch_total = 0;
      answer_q.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        limit_q = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (answer_q.size() == 0) begin
          mismatch_total++;
          $display("%0t: result with nothing outstanding, expected none, actual %0d/%0d",
                   $time, out_data_i.prime_flag, out_data_i.prime_count);
        end else begin
          want = answer_q.pop_front();
          if (out_data_i.prime_flag !== want.prime_flag) begin
            flag_mismatch("prime_flag", want.prime_flag, out_data_i.prime_flag);
          end
          if (out_data_i.prime_count !== want.prime_count) begin
            flag_mismatch("prime_count", want.prime_count, out_data_i.prime_count);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.command == CMD_BUILD) begin
          rebuild_table();
          want.prime_flag = 1'b0;
        end else begin
          want.prime_flag = answer_query(in_data_i.query_value);
        end
        want.prime_count = prime_total[COUNT_OUT_W-1:0];
        answer_q = {answer_q, want};
      end
      fail_count_o  <= mismatch_total;
      outstanding_o <= answer_q.size();
    end
  end

endmodule

/* sim/prime_table_builder_and_query_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime table unit testbench
// Drives build and query requests and limit writes into the prime table unit
// with random gaps and result stalls; a checker beside the unit predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module prime_table_builder_and_query_unit_test;
  import ptb_pkg::*;

  localparam int unsigned LIMIT_MAX    = 4096;
  localparam int unsigned TABLE_DEPTH  = 1024;
  localparam int unsigned IDLE_PCT     = 18;
  localparam int unsigned RANDOM_ITEMS = 1000;
  // A build at the largest limit runs without any handshake until it finishes.
  localparam int unsigned STALL_LIMIT  = 20_000_000;

  logic         clk_i;
  logic         rst_ni;
  bit           calm;
  int unsigned  fail_count;
  int unsigned  outstanding;
  int unsigned  sent_total;
  int unsigned  stall_cycles;
  prime_limit_t cur_limit;

  ptb_chan_if #(.T(ptb_in_t))      in_req  ();
  ptb_chan_if #(.T(ptb_out_t))     out_rsp ();
  ptb_chan_if #(.T(prime_limit_t)) cfg_req ();

  prime_table_builder_and_query_unit #(
    .LIMIT_MAX  (LIMIT_MAX),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_req (in_req),
    .out_rsp(out_rsp),
    .cfg_req(cfg_req)
  );

  prime_table_builder_and_query_unit_checker #(
    .LIMIT_MAX  (LIMIT_MAX),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_req.valid),
    .in_ready_i   (in_req.ready),
    .in_data_i    (in_req.data),
    .out_valid_i  (out_rsp.valid),
    .out_ready_i  (out_rsp.ready),
    .out_data_i   (out_rsp.data),
    .cfg_valid_i  (cfg_req.valid),
    .cfg_ready_i  (cfg_req.ready),
    .cfg_data_i   (cfg_req.data),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_rsp.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) ||
        (cfg_req.valid && cfg_req.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Starts and ends at a falling edge; valid is left high so that the next
  // request can follow without a gap.
  task automatic send_request(ptb_cmd_e cmd, logic [VALUE_W-1:0] value);
    ptb_in_t req;
    req.command     = cmd;
    req.query_value = value;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_req.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_req.valid <= 1'b1;
    in_req.data  <= req;
    @(posedge clk_i);
    while (!in_req.ready) @(posedge clk_i);
    sent_total++;
    @(negedge clk_i);
  endtask

  task automatic drain_requests();
    in_req.valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk_i);
  endtask

  // The limit is only changed once the unit has answered everything.
  task automatic write_limit(prime_limit_t value);
    drain_requests();
    cfg_req.valid <= 1'b1;
    cfg_req.data  <= value;
    @(posedge clk_i);
    while (!cfg_req.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_req.valid <= 1'b0;
    cur_limit = value;
  endtask

  initial begin
    int unsigned        base;
    int unsigned        pick;
    int unsigned        lim;
    int unsigned        phase_len;
    logic [VALUE_W-1:0] value;
    rst_ni        = 1'b0;
    calm          = 1'b0;
    sent_total    = 0;
    cur_limit     = PRIME_LIMIT_RESET;
    in_req.valid  = 1'b0;
    in_req.data   = '0;
    cfg_req.valid = 1'b0;
    cfg_req.data  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Before any build the table is empty, so even a prime answers not prime.
    send_request(CMD_QUERY, 32'd7);
    send_request(CMD_QUERY, 32'h8000_0000);
    // Build with the limit left at its reset value; the value field is ignored.
    send_request(CMD_BUILD, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 32'd2);
    send_request(CMD_QUERY, 32'd3);
    send_request(CMD_QUERY, 32'd97);
    send_request(CMD_QUERY, 32'd100);
    send_request(CMD_QUERY, 32'd101);
    send_request(CMD_QUERY, 32'd0);
    send_request(CMD_QUERY, 32'd1);
    send_request(CMD_QUERY, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 32'hFFFF_FFF9);
    send_request(CMD_QUERY, 32'h7FFF_FFFF);
    send_request(CMD_QUERY, 32'h8000_0000);
    send_request(CMD_QUERY, 32'd9409);
    // Limits below two leave the table empty.
    write_limit(12'd0);
    send_request(CMD_BUILD, 32'd0);
    send_request(CMD_QUERY, 32'd2);
    write_limit(12'd1);
    send_request(CMD_BUILD, 32'd0);
    write_limit(12'd2);
    send_request(CMD_BUILD, 32'd0);
    send_request(CMD_QUERY, 32'd2);
    send_request(CMD_QUERY, 32'd4);
    write_limit(12'hFFF);
    send_request(CMD_BUILD, 32'd0);
    send_request(CMD_QUERY, 32'd4093);
    send_request(CMD_QUERY, 32'd4096);
    send_request(CMD_QUERY, 32'h7FFF_FFFF);

    // Random phases: a new limit, usually a build, then mostly queries.
    base = sent_total;
    while (sent_total - base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) lim = $urandom_range(0, 150);
      else if (pick < 95) lim = $urandom_range(151, 400);
      else lim = $urandom_range(401, 600);
      write_limit(lim[PRIME_LIMIT_W-1:0]);
      if ($urandom_range(0, 9) != 0) send_request(CMD_BUILD, $urandom());
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        calm = (sent_total - base >= 300) && (sent_total - base < 500);
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          send_request(CMD_BUILD, $urandom());
        end else begin
          if (pick < 40) begin
            value = $urandom_range(0, cur_limit + 20);
          end else if (pick < 52) begin
            value = 32'd0 - $urandom_range(0, cur_limit + 20);
          end else if (pick < 72) begin
            value = $urandom();
          end else if (pick < 84) begin
            value = $urandom_range(2, 70) * $urandom_range(2, 70);
          end else if (pick < 92) begin
            case ($urandom_range(0, 5))
              0: value = 32'd0;
              1: value = 32'd1;
              2: value = 32'd2;
              3: value = 32'hFFFF_FFFF;
              4: value = 32'h7FFF_FFFF;
              default: value = 32'h8000_0000;
            endcase
          end else begin
            // Large odd positives often have no small factor and walk the table.
            value = ($urandom() & 32'h7FFF_FFFF) | 32'd1;
          end
          send_request(CMD_QUERY, value);
        end
      end
    end

    calm = 1'b0;
    drain_requests();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
